// ===== hw/rtl/script_record_string_decryptor_defines.svh =====
// assertion macros used by the string decryptor parser (srsd_front)
`ifndef SCRIPT_RECORD_STRING_DECRYPTOR_DEFINES_SVH
`define SCRIPT_RECORD_STRING_DECRYPTOR_DEFINES_SVH

// condition on this edge implies consequence on this edge
`define SRSD_ASSERT_IMP(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error("srsd assertion failed");

// condition on this edge implies consequence on the next edge
`define SRSD_ASSERT_NXT(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error("srsd assertion failed");

`endif

// ===== hw/rtl/srsd_pkg.sv =====
// shared types and constants of the record string decryptor
package srsd_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_COUNT = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // record codes
  localparam logic [7:0] CODE_SKIP = 8'h01;
  localparam logic [7:0] CODE_STR  = 8'h02;
  localparam logic [7:0] CODE_END  = 8'hFF;

  localparam logic [2:0]  SKIP_LEN     = 3'd4;
  localparam logic [31:0] KEY_SEED_RST = 32'h4B5A_B4A5;

  // command queue, depth is a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [6:0] {
    PH_CODE  = 7'b0000001,
    PH_SKIP  = 7'b0000010,
    PH_LENLO = 7'b0000100,
    PH_LENHI = 7'b0001000,
    PH_STR   = 7'b0010000,
    PH_DONE  = 7'b0100000,
    PH_FAIL  = 7'b1000000
  } phase_t;

  // one command from parser to decrypt side
  typedef struct packed {
    logic [1:0]  kind;
    logic        first;  // first byte of a string, load key from seed
    logic [31:0] seed;   // key seed taken when the string length completed
    logic [7:0]  data;   // cipher byte for KIND_BYTE
    logic        eos;
    logic [15:0] count;  // capped record count for KIND_COUNT
  } cmd_t;

  // queue status seen by the parser
  typedef struct packed {
    logic full;
  } q_stat_t;

endpackage

// ===== hw/rtl/srsd_queue.sv =====
// short command queue between parser and decrypt stage
module srsd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  srsd_pkg::cmd_t   push_cmd,
  output srsd_pkg::q_stat_t stat,
  input  logic             pop,
  output logic             pop_valid,
  output srsd_pkg::cmd_t   pop_cmd
);
  import srsd_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full = (cnt_r == QCNT_W'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/srsd_front.sv =====
// record parser: classifies input bytes and queues commands
`include "script_record_string_decryptor_defines.svh"

module srsd_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              end_of_data,
  input  logic              restart,
  input  logic [31:0]       key_seed,
  input  srsd_pkg::q_stat_t q_stat,
  output logic              push,
  output srsd_pkg::cmd_t    push_cmd
);
  import srsd_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [2:0]            skip_r, skip_nxt;
  logic [7:0]            len_lo_r, len_lo_nxt;
  logic [15:0]           left_r, left_nxt;
  logic                  first_r, first_nxt;
  logic [31:0]           str_seed_r, str_seed_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  accept;
  logic                  parked;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign parked   = (phase_r == PH_DONE) || (phase_r == PH_FAIL);

  // parse step for one request
  always_comb begin
    phase_t                     cur;
    logic [COUNT_BITS-1:0]      cur_cnt;
    logic [COUNT_BITS+15:0]     cnt_ext;
    logic [COUNT_BITS-1:0]      cnt_inc;
    logic [15:0]                cnt_cap;
    logic [15:0]                len_full;

    cur      = restart ? PH_CODE : phase_r;
    cur_cnt  = restart ? '0 : cnt_r;
    cnt_ext  = {16'h0, cur_cnt};
    cnt_cap  = (|cnt_ext[COUNT_BITS+15:16]) ? 16'hFFFF : cnt_ext[15:0];
    cnt_inc  = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
    len_full = {data_byte, len_lo_r};

    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    len_lo_nxt = len_lo_r;
    left_nxt  = left_r;
    first_nxt = first_r;
    str_seed_nxt = str_seed_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    push_cmd  = '0;

    if (accept) begin
      phase_nxt = cur;
      cnt_nxt   = cur_cnt;
      if (cur == PH_DONE || cur == PH_FAIL) begin
        // parked until restart
      end else if (end_of_data) begin
        push = 1'b1;
        if (cur == PH_CODE) begin
          push_cmd.kind  = KIND_COUNT;
          push_cmd.count = cnt_cap;
          phase_nxt      = PH_DONE;
        end else begin
          push_cmd.kind = KIND_ERROR;
          phase_nxt     = PH_FAIL;
        end
      end else begin
        unique case (cur)
          PH_CODE: begin
            if (data_byte == CODE_END) begin
              push           = 1'b1;
              push_cmd.kind  = KIND_COUNT;
              push_cmd.count = cnt_cap;
              phase_nxt      = PH_DONE;
            end else if (data_byte == CODE_SKIP) begin
              skip_nxt  = SKIP_LEN;
              phase_nxt = PH_SKIP;
            end else if (data_byte == CODE_STR) begin
              phase_nxt = PH_LENLO;
            end else begin
              push          = 1'b1;
              push_cmd.kind = KIND_ERROR;
              phase_nxt     = PH_FAIL;
            end
          end
          PH_SKIP: begin
            skip_nxt = skip_r - 1'b1;
            if (skip_r == 3'd1) begin
              cnt_nxt   = cnt_inc;
              phase_nxt = PH_CODE;
            end
          end
          PH_LENLO: begin
            len_lo_nxt = data_byte;
            phase_nxt  = PH_LENHI;
          end
          PH_LENHI: begin
            left_nxt = len_full;
            if (len_full == 16'h0) begin
              push          = 1'b1;
              push_cmd.kind = KIND_EMPTY;
              cnt_nxt       = cnt_inc;
              phase_nxt     = PH_CODE;
            end else begin
              // the string keeps the seed that is current now
              first_nxt    = 1'b1;
              str_seed_nxt = key_seed;
              phase_nxt    = PH_STR;
            end
          end
          PH_STR: begin
            push           = 1'b1;
            push_cmd.kind  = KIND_BYTE;
            push_cmd.first = first_r;
            push_cmd.seed  = str_seed_r;
            push_cmd.data  = data_byte;
            push_cmd.eos   = (left_r == 16'h1);
            left_nxt       = left_r - 1'b1;
            first_nxt      = 1'b0;
            if (left_r == 16'h1) begin
              cnt_nxt   = cnt_inc;
              phase_nxt = PH_CODE;
            end
          end
          default: begin
            phase_nxt = PH_FAIL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CODE;
      skip_r     <= '0;
      len_lo_r   <= '0;
      left_r     <= '0;
      first_r    <= 1'b0;
      str_seed_r <= KEY_SEED_RST;
      cnt_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      skip_r     <= skip_nxt;
      len_lo_r   <= len_lo_nxt;
      left_r     <= left_nxt;
      first_r    <= first_nxt;
      str_seed_r <= str_seed_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // commands only come from accepted requests
  `SRSD_ASSERT_IMP(a_push_on_accept, clk, rst_n, push, accept)
  // a parked parser stays silent until restart
  `SRSD_ASSERT_IMP(a_parked_silent, clk, rst_n, accept && !restart && parked, !push)
  // skip phase always has bytes left to drop
  `SRSD_ASSERT_IMP(a_skip_nonzero, clk, rst_n, phase_r == PH_SKIP, skip_r != 3'd0)
  // a string request that ends a record returns to code phase
  `SRSD_ASSERT_NXT(a_eos_to_code, clk, rst_n, push && push_cmd.eos, phase_r == PH_CODE)

endmodule

// ===== hw/rtl/srsd_back.sv =====
// decrypt stage: running key, result formatting and output register
module srsd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [31:0]    cfg_wr_data,
  output logic [31:0]    key_seed,
  input  logic           q_valid,
  input  srsd_pkg::cmd_t q_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_kind,
  output logic [7:0]     plain_byte,
  output logic           end_of_string,
  output logic [15:0]    records_seen
);
  import srsd_pkg::*;

  logic [31:0] seed_r;
  logic [31:0] key_r, key_nxt;
  logic        valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  plain_r;
  logic        eos_r;
  logic [15:0] recs_r;
  logic [31:0] key_cur;
  logic [7:0]  plain_cur;

  assign pop      = q_valid && (!valid_r || out_ready);
  assign key_seed = seed_r;

  // key step for one string byte
  always_comb begin
    key_cur   = q_cmd.first ? q_cmd.seed : key_r;
    plain_cur = q_cmd.data ^ key_cur[7:0];
    key_nxt   = key_r;
    if (pop && q_cmd.kind == KIND_BYTE) begin
      key_nxt = {24'h0, plain_cur}
              ^ ({key_cur[22:0], 9'h0} | {23'h0, key_cur[31:27], 4'h0});
    end
  end

  // seed register and running key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= KEY_SEED_RST;
      key_r  <= KEY_SEED_RST;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      key_r <= key_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= q_cmd.kind;
      plain_r <= (q_cmd.kind == KIND_BYTE) ? plain_cur : 8'h0;
      eos_r   <= (q_cmd.kind == KIND_BYTE) && q_cmd.eos;
      recs_r  <= (q_cmd.kind == KIND_COUNT) ? q_cmd.count : 16'h0;
    end
  end

  assign out_valid     = valid_r;
  assign out_kind      = kind_r;
  assign plain_byte    = plain_r;
  assign end_of_string = eos_r;
  assign records_seen  = recs_r;

endmodule

// ===== hw/rtl/script_record_string_decryptor.sv =====
// top level of the script record string decryptor
//
//   channel  | ports                         | carries
//   ---------+-------------------------------+----------------------------------
//   input    | in_tvalid/tready/tdata/tlast/ | one record-area byte per request
//            | tuser                         |
//   result   | out_tvalid/tready/tdata/tlast/| plain byte, empty, count or error
//            | tuser                         |
//   config   | cfg_wr_en/cfg_wr_data         | key seed
//
// one request per cycle; in_tready drops only when the command queue is full.
// a result passes the parser, a four-entry command queue and the decrypt
// output register. the key update is a shift and xor in the decrypt stage,
// one byte per cycle while the output register is empty or out_tready is high.
// synchronous active-low reset, no clearing pass.
module script_record_string_decryptor #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_data
  input  logic        in_tuser,   // restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] plain_byte, [23:8] records_seen
  output logic        out_tlast,  // end_of_string
  output logic [1:0]  out_tuser,  // [1:0] out_kind
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import srsd_pkg::*;

  q_stat_t     q_stat;
  logic        push;
  cmd_t        push_cmd;
  logic        q_valid;
  cmd_t        q_cmd;
  logic        pop;
  logic [31:0] key_seed;
  logic [7:0]  plain_byte;
  logic [15:0] records_seen;

  srsd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .data_byte  (in_tdata),
    .end_of_data(in_tlast),
    .restart    (in_tuser),
    .key_seed   (key_seed),
    .q_stat     (q_stat),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  srsd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .stat     (q_stat),
    .pop      (pop),
    .pop_valid(q_valid),
    .pop_cmd  (q_cmd)
  );

  srsd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .key_seed     (key_seed),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (out_tuser),
    .plain_byte   (plain_byte),
    .end_of_string(out_tlast),
    .records_seen (records_seen)
  );

  assign out_tdata = {records_seen, plain_byte};

endmodule
